[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge out of reset.
`define BTMX_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BTMX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BTMX_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define BTMX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/btmx_pkg.sv]
// ----------------------------------------------------------------------------
// btmx_pkg
// Types, codes and default sizes for the binary trie maximum-XOR block.
// ----------------------------------------------------------------------------
package btmx_pkg;

  // Default sizes of the trie.
  localparam int KEY_BITS_DEF = 32;
  localparam int NODES_DEF    = 65536;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Input word.
  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [31:0] max_xor;
    logic [1:0]  status;
  } out_word_t;

endpackage

[rtl/binary_trie_max_xor.sv]
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Binary trie of keys in a node store, answering maximum-XOR queries.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_word) takes one word a time:
//   req_type selects an insert of key or a query of the largest XOR of key
//   with any stored key. Every input word yields exactly one result word on
//   the output channel (out_valid, out_stall, out_word) with max_xor and a
//   status of done, empty trie or store full.
//   A walked item does one node-store read per trie level, each level's
//   read address coming from the data of the level above, until the last
//   level or a query finding no child; the hold state then loads the result.
//   An empty query or a refused insert goes from acceptance straight to the
//   hold state. One item is in work at a time and the input reopens once
//   the result is loaded, so a new word is not taken before the last one
//   is through.
//   While the result register is full and out_stall is high, a finished
//   item waits in the block and in_stall stays high; a new word may be
//   accepted while an earlier result still waits to be taken.
//   Reset empties the trie at once: the root reads as cleared until it is
//   first written and the allocation counter returns to one. No clearing
//   pass is needed, since a node allocated in a walk reads as having no children.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_trie_max_xor #(
  parameter int KEY_BITS = btmx_pkg::KEY_BITS_DEF,
  parameter int NODES    = btmx_pkg::NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  btmx_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output btmx_pkg::out_word_t out_word
);

  localparam int AW    = $clog2(NODES);
  localparam int DW    = 2 * AW;
  localparam int NF_W  = $clog2(NODES + 1);
  localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  localparam logic [NF_W-1:0]     FULL_LIM = NF_W'(NODES - KEY_BITS);
  localparam logic [NF_W-1:0]     NODES_NF = NF_W'(NODES);
  localparam logic [KEY_BITS-1:0] MASK_TOP = KEY_BITS'(1) << (KEY_BITS - 1);
  localparam logic [LVL_W-1:0]    LVL_TOP  = LVL_W'(KEY_BITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  btmx_pkg::out_word_t out_word_r, out_word_nxt;
  logic [NF_W-1:0]     next_free_r, next_free_nxt;
  logic                root_valid_r, root_valid_nxt;
  logic                rd_root_r;
  logic                alloc_r, alloc_nxt;
  logic                req_r, req_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] mask_r, mask_nxt;
  logic [KEY_BITS-1:0] acc_r, acc_nxt;
  logic [AW-1:0]       node_r, node_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [1:0]          res_status_r, res_status_nxt;

  logic                in_acc;
  logic                store_full;
  logic                trie_empty;
  logic [DW-1:0]       ent;
  logic [AW-1:0]       link0;
  logic [AW-1:0]       link1;
  logic                key_bit;
  logic [AW-1:0]       hit;
  logic [AW-1:0]       other;
  logic [AW-1:0]       new_node;
  logic                stop;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [DW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [DW-1:0]       mem_rdata;

  // Node store.
  btmx_node_ram #(
    .DEPTH (NODES),
    .AW    (AW),
    .DW    (DW)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshake and occupancy checks.
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign store_full = (next_free_r > FULL_LIM);
  assign trie_empty = (next_free_r <= NF_W'(1));
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;

  // Current node entry. A node allocated in this walk, or the root before
  // its first write, reads as having no children.
  always_comb begin
    ent = mem_rdata;
    if (alloc_r || (rd_root_r && !root_valid_r)) begin
      ent = '0;
    end
    link0    = ent[AW-1:0];
    link1    = ent[DW-1:AW];
    key_bit  = |(key_r & mask_r);
    hit      = key_bit ? link1 : link0;
    other    = key_bit ? link0 : link1;
    new_node = next_free_r[AW-1:0];
  end

  // Walk control and next-state logic.
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    next_free_nxt  = next_free_r;
    root_valid_nxt = root_valid_r;
    alloc_nxt      = alloc_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    mask_nxt       = mask_r;
    acc_nxt        = acc_r;
    node_nxt       = node_r;
    lvl_nxt        = lvl_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = node_r;
    mem_wdata      = '0;
    mem_raddr      = '0;
    stop           = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // The root is read on acceptance so that its entry is ready next.
        if (in_acc) begin
          req_nxt        = in_word.req_type;
          key_nxt        = in_word.key[KEY_BITS-1:0];
          mask_nxt       = MASK_TOP;
          acc_nxt        = '0;
          alloc_nxt      = 1'b0;
          node_nxt       = '0;
          lvl_nxt        = LVL_TOP;
          res_status_nxt = btmx_pkg::STATUS_DONE;
          if (in_word.req_type == btmx_pkg::REQ_INSERT && store_full) begin
            res_status_nxt = btmx_pkg::STATUS_FULL;
            state_nxt      = S_HOLD;
          end else if (in_word.req_type == btmx_pkg::REQ_QUERY && trie_empty) begin
            res_status_nxt = btmx_pkg::STATUS_EMPTY;
            state_nxt      = S_HOLD;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (req_r == btmx_pkg::REQ_INSERT) begin
          // Follow the key bit; a missing child is allocated and linked in.
          // The write also clears the other link of a freshly allocated node.
          if (hit == '0) begin
            mem_we        = 1'b1;
            mem_wdata     = key_bit ? {new_node, link0} : {link1, new_node};
            next_free_nxt = next_free_r + NF_W'(1);
            alloc_nxt     = 1'b1;
            node_nxt      = new_node;
            if (node_r == '0) begin
              root_valid_nxt = 1'b1;
            end
          end else begin
            node_nxt = hit;
          end
        end else begin
          // Prefer the opposite bit; fall back to the same bit, and stop
          // where neither child exists.
          if (other != '0) begin
            acc_nxt  = acc_r | mask_r;
            node_nxt = other;
          end else if (hit != '0) begin
            node_nxt = hit;
          end else begin
            stop = 1'b1;
          end
        end
        mem_raddr = node_nxt;
        mask_nxt  = mask_r >> 1;
        lvl_nxt   = lvl_r - LVL_W'(1);
        if (stop || lvl_r == '0) begin
          state_nxt = S_HOLD;
        end
      end

      S_HOLD: begin
        // Load the result once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_word_nxt.max_xor = 32'(acc_r);
          out_word_nxt.status  = res_status_r;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      next_free_r  <= NF_W'(1);
      root_valid_r <= 1'b0;
      alloc_r      <= 1'b0;
      rd_root_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      next_free_r  <= next_free_nxt;
      root_valid_r <= root_valid_nxt;
      alloc_r      <= alloc_nxt;
      rd_root_r    <= (mem_raddr == '0);
      out_word_r   <= out_word_nxt;
    end
  end

  // Walk datapath registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    mask_r       <= mask_nxt;
    acc_r        <= acc_nxt;
    node_r       <= node_nxt;
    lvl_r        <= lvl_nxt;
    res_status_r <= res_status_nxt;
  end

  // Assertions.
  `BTMX_ASSERT_ALWAYS(a_free_in_range, clk, rst_n, next_free_r <= NODES_NF, "next_free beyond store")
  `BTMX_ASSERT_ALWAYS(a_no_rw_clash, clk, rst_n, !mem_we || (mem_waddr != mem_raddr), "write and read hit one node")
  `BTMX_ASSERT_ALWAYS(a_write_in_insert, clk, rst_n, !mem_we || (state_r == S_WALK && req_r == btmx_pkg::REQ_INSERT), "store written outside an insert walk")
  `BTMX_ASSERT_NEXT(a_full_keeps_free, clk, rst_n, in_acc && in_word.req_type == btmx_pkg::REQ_INSERT && store_full, state_r == S_HOLD && $stable(next_free_r), "refused insert changed the trie")
  `BTMX_ASSERT_NEXT(a_hold_waits, clk, rst_n, state_r == S_HOLD && out_valid_r && out_stall, state_r == S_HOLD, "result dropped while output stalled")

endmodule

[rtl/btmx_node_ram.sv]
// ----------------------------------------------------------------------------
// btmx_node_ram
// Node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btmx_node_ram #(
  parameter int DEPTH = btmx_pkg::NODES_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 2 * AW
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
